### rtl/smalu_pkg.sv
// ----------------------------------------------------------------------------
// smalu_pkg
// Shared types and operation codes of the 8/16-bit ALU with flags.
// ----------------------------------------------------------------------------
package smalu_pkg;

   localparam logic [4:0] FUNC_ADD   = 5'd0;
   localparam logic [4:0] FUNC_ADC   = 5'd1;
   localparam logic [4:0] FUNC_SUB   = 5'd2;
   localparam logic [4:0] FUNC_SBC   = 5'd3;
   localparam logic [4:0] FUNC_AND   = 5'd4;
   localparam logic [4:0] FUNC_XOR   = 5'd5;
   localparam logic [4:0] FUNC_OR    = 5'd6;
   localparam logic [4:0] FUNC_CP    = 5'd7;
   localparam logic [4:0] FUNC_INC   = 5'd8;
   localparam logic [4:0] FUNC_DEC   = 5'd9;
   localparam logic [4:0] FUNC_DAA   = 5'd10;
   localparam logic [4:0] FUNC_CPL   = 5'd11;
   localparam logic [4:0] FUNC_SCF   = 5'd12;
   localparam logic [4:0] FUNC_CCF   = 5'd13;
   localparam logic [4:0] FUNC_RLCA  = 5'd14;
   localparam logic [4:0] FUNC_RLA   = 5'd15;
   localparam logic [4:0] FUNC_RRCA  = 5'd16;
   localparam logic [4:0] FUNC_RRA   = 5'd17;
   localparam logic [4:0] FUNC_ADD16 = 5'd18;
   localparam logic [4:0] FUNC_ADDSP = 5'd19;

   localparam logic [7:0] DAA_SUB_LO  = 8'hFA;
   localparam logic [7:0] DAA_SUB_HI  = 8'hA0;
   localparam logic [8:0] DAA_ADD_LO  = 9'h006;
   localparam logic [8:0] DAA_ADD_HI  = 9'h060;
   localparam logic [3:0] DAA_DIG_MAX = 4'h9;
   localparam logic [4:0] DAA_TOP_MAX = 5'h09;

   typedef struct packed {
      logic [4:0]  func;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic        zero_in;
      logic        subtract_in;
      logic        half_in;
      logic        carry_in;
   } alu_req_type;

   typedef struct packed {
      logic [15:0] result;
      logic        write_result;
      logic        zero_out;
      logic        subtract_out;
      logic        half_out;
      logic        carry_out;
   } alu_rsp_type;

endpackage

### rtl/sm83_alu_with_flags_unit.sv
// ----------------------------------------------------------------------------
// sm83_alu_with_flags_unit
// 8-bit ALU with Z/N/H/C flags, decimal adjust, rotates and 16-bit adds.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/ready   | req_data (alu_req_type)
//   rsp     | out       | rsp_valid/ready   | rsp_data (alu_rsp_type)
//
// One word per cycle sustained while rsp_ready stays high; a word passes the
// input register, then the result register after the adders and muxes.
// Synchronous active-high reset empties both stages.
// A stalled result holds in the result register while the input register
// still takes one more word; req_ready drops only when both are full.
// ----------------------------------------------------------------------------
module sm83_alu_with_flags_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  smalu_pkg::alu_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output smalu_pkg::alu_rsp_type rsp_data
);
   import smalu_pkg::*;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   alu_req_type s1_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   alu_rsp_type rsp_ff;
   alu_rsp_type calc;
   logic        rsp_free;
   logic        s1_adv;

   logic [7:0]  a;
   logic [7:0]  b;
   logic        t;
   logic [8:0]  sum9;
   logic [4:0]  hsum5;
   logic [8:0]  diff9;
   logic [4:0]  hdiff5;
   logic [7:0]  daa_sub;
   logic [8:0]  daa_lo;
   logic [8:0]  daa_hi;
   logic        daa_c;
   logic [16:0] sum17;
   logic [12:0] hsum13;
   logic [15:0] sp_sum;
   logic [8:0]  sp_byte;
   logic [4:0]  sp_nib;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && rsp_free;
   assign req_ready = !s1_valid_ff || rsp_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !rsp_free);
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_ff <= calc;
      end
   end

   always_comb begin
      a       = s1_ff.operand_a[7:0];
      b       = s1_ff.operand_b[7:0];
      t       = ((s1_ff.func == FUNC_ADC) || (s1_ff.func == FUNC_SBC)) && s1_ff.carry_in;
      sum9    = {1'b0, a} + {1'b0, b} + {8'h00, t};
      hsum5   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t};
      diff9   = {1'b0, a} - {1'b0, b} - {8'h00, t};
      hdiff5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, t};
      daa_sub = a + (s1_ff.half_in ? DAA_SUB_LO : 8'h00)
                  + (s1_ff.carry_in ? DAA_SUB_HI : 8'h00);
      daa_lo  = {1'b0, a} + (((a[3:0] > DAA_DIG_MAX) || s1_ff.half_in) ? DAA_ADD_LO : 9'h000);
      daa_c   = (daa_lo[8:4] > DAA_TOP_MAX) || s1_ff.carry_in;
      daa_hi  = daa_lo + (daa_c ? DAA_ADD_HI : 9'h000);
      sum17   = {1'b0, s1_ff.operand_a} + {1'b0, s1_ff.operand_b};
      hsum13  = {1'b0, s1_ff.operand_a[11:0]} + {1'b0, s1_ff.operand_b[11:0]};
      sp_sum  = s1_ff.operand_a + {{8{b[7]}}, b};
      sp_byte = {1'b0, s1_ff.operand_a[7:0]} + {1'b0, b};
      sp_nib  = {1'b0, s1_ff.operand_a[3:0]} + {1'b0, b[3:0]};

      calc.result       = s1_ff.operand_a;
      calc.write_result = 1'b0;
      calc.zero_out     = s1_ff.zero_in;
      calc.subtract_out = s1_ff.subtract_in;
      calc.half_out     = s1_ff.half_in;
      calc.carry_out    = s1_ff.carry_in;

      case (s1_ff.func)
         FUNC_ADD, FUNC_ADC: begin
            calc = '{{8'h00, sum9[7:0]}, 1'b1, sum9[7:0] == 8'h00, 1'b0, hsum5[4], sum9[8]};
         end
         FUNC_SUB, FUNC_SBC, FUNC_CP: begin
            calc = '{{8'h00, diff9[7:0]}, s1_ff.func != FUNC_CP, diff9[7:0] == 8'h00,
                     1'b1, hdiff5[4], diff9[8]};
         end
         FUNC_AND: begin
            calc = '{{8'h00, a & b}, 1'b1, (a & b) == 8'h00, 1'b0, 1'b1, 1'b0};
         end
         FUNC_XOR: begin
            calc = '{{8'h00, a ^ b}, 1'b1, (a ^ b) == 8'h00, 1'b0, 1'b0, 1'b0};
         end
         FUNC_OR: begin
            calc = '{{8'h00, a | b}, 1'b1, (a | b) == 8'h00, 1'b0, 1'b0, 1'b0};
         end
         FUNC_INC: begin
            calc = '{{8'h00, a + 8'h01}, 1'b1, a == 8'hFF, 1'b0, a[3:0] == 4'hF,
                     s1_ff.carry_in};
         end
         FUNC_DEC: begin
            calc = '{{8'h00, a - 8'h01}, 1'b1, a == 8'h01, 1'b1, a[3:0] == 4'h0,
                     s1_ff.carry_in};
         end
         FUNC_DAA: begin
            if (s1_ff.subtract_in) begin
               calc = '{{8'h00, daa_sub}, 1'b1, daa_sub == 8'h00, 1'b1, 1'b0,
                        s1_ff.carry_in};
            end else begin
               calc = '{{8'h00, daa_hi[7:0]}, 1'b1, daa_hi[7:0] == 8'h00, 1'b0, 1'b0,
                        daa_c};
            end
         end
         FUNC_CPL: begin
            calc = '{{8'h00, ~a}, 1'b1, s1_ff.zero_in, 1'b1, 1'b1, s1_ff.carry_in};
         end
         FUNC_SCF: begin
            calc = '{{8'h00, a}, 1'b0, s1_ff.zero_in, 1'b0, 1'b0, 1'b1};
         end
         FUNC_CCF: begin
            calc = '{{8'h00, a}, 1'b0, s1_ff.zero_in, 1'b0, 1'b0, !s1_ff.carry_in};
         end
         FUNC_RLCA: begin
            calc = '{{8'h00, a[6:0], a[7]}, 1'b1, 1'b0, 1'b0, 1'b0, a[7]};
         end
         FUNC_RLA: begin
            calc = '{{8'h00, a[6:0], s1_ff.carry_in}, 1'b1, 1'b0, 1'b0, 1'b0, a[7]};
         end
         FUNC_RRCA: begin
            calc = '{{8'h00, a[0], a[7:1]}, 1'b1, 1'b0, 1'b0, 1'b0, a[0]};
         end
         FUNC_RRA: begin
            calc = '{{8'h00, s1_ff.carry_in, a[7:1]}, 1'b1, 1'b0, 1'b0, 1'b0, a[0]};
         end
         FUNC_ADD16: begin
            calc = '{sum17[15:0], 1'b1, s1_ff.zero_in, 1'b0, hsum13[12], sum17[16]};
         end
         FUNC_ADDSP: begin
            calc = '{sp_sum, 1'b1, 1'b0, 1'b0, sp_nib[4], sp_byte[8]};
         end
         default: begin
            calc.result = s1_ff.operand_a;
         end
      endcase
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted word lost from input register");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_free) |=> s1_valid_ff && $stable(s1_ff))
      else $error("stalled input register changed");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled while pipeline has room");
`endif

endmodule

### test/sm83_alu_with_flags_checker.sv
// ----------------------------------------------------------------------------
// sm83_alu_with_flags_checker
// Watches both channels of the ALU. Each accepted request word is turned into
// the expected result and flags, queued in order, and compared field by field
// with each accepted result word. Hands the failure count and the number of
// outstanding results to the testbench top.
// ----------------------------------------------------------------------------
module sm83_alu_with_flags_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  smalu_pkg::alu_req_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  smalu_pkg::alu_rsp_type rsp_data,
   output int                     fail_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import smalu_pkg::*;

   localparam int REPORT_LIMIT = 10;

   alu_rsp_type expected_q[$];
   int          errors  = 0;
   int          reports = 0;

   function automatic alu_rsp_type flag_word(input int unsigned r, input bit wr,
                                             input bit z, input bit n,
                                             input bit h, input bit c);
      alu_rsp_type p;
      p.result       = r[15:0];
      p.write_result = wr;
      p.zero_out     = z;
      p.subtract_out = n;
      p.half_out     = h;
      p.carry_out    = c;
      return p;
   endfunction

   function automatic alu_rsp_type alu_outcome(input alu_req_type w);
      int unsigned wa, wb, a, b, t, r, cy;
      bit          zi, ni, hi, ci, hc;
      wa = 32'(w.operand_a);
      wb = 32'(w.operand_b);
      a  = 32'(w.operand_a[7:0]);
      b  = 32'(w.operand_b[7:0]);
      zi = w.zero_in;
      ni = w.subtract_in;
      hi = w.half_in;
      ci = w.carry_in;
      case (w.func)
         FUNC_ADD, FUNC_ADC: begin
            t  = (w.func == FUNC_ADC) ? 32'(ci) : 32'd0;
            r  = a + b + t;
            hc = ((a & 'hF) + (b & 'hF) + t) >= 'h10;
            return flag_word(r & 'hFF, 1'b1, (r & 'hFF) == 0, 1'b0, hc, r >= 'h100);
         end
         FUNC_SUB, FUNC_SBC, FUNC_CP: begin
            t  = (w.func == FUNC_SBC) ? 32'(ci) : 32'd0;
            r  = (a - b - t) & 'hFF;
            hc = (a & 'hF) < ((b & 'hF) + t);
            return flag_word(r, w.func != FUNC_CP, r == 0, 1'b1, hc, a < (b + t));
         end
         FUNC_AND: return flag_word(a & b, 1'b1, (a & b) == 0, 1'b0, 1'b1, 1'b0);
         FUNC_XOR: return flag_word(a ^ b, 1'b1, (a ^ b) == 0, 1'b0, 1'b0, 1'b0);
         FUNC_OR:  return flag_word(a | b, 1'b1, (a | b) == 0, 1'b0, 1'b0, 1'b0);
         FUNC_INC: begin
            r = (a + 1) & 'hFF;
            return flag_word(r, 1'b1, r == 0, 1'b0, (a & 'hF) == 'hF, ci);
         end
         FUNC_DEC: begin
            r = (a - 1) & 'hFF;
            return flag_word(r, 1'b1, r == 0, 1'b1, (a & 'hF) == 0, ci);
         end
         FUNC_DAA: begin
            r  = a;
            cy = 32'(ci);
            if (ni) begin
               if (hi) r = (r + 'hFA) & 'hFF;
               if (ci) r = (r + 'hA0) & 'hFF;
            end else begin
               if ((r & 'hF) > 'h9 || hi) r += 'h6;
               if ((r & 'h1F0) > 'h90 || ci) begin
                  r += 'h60;
                  cy = 1;
               end else begin
                  cy = 0;
               end
               r &= 'hFF;
            end
            return flag_word(r, 1'b1, r == 0, ni, 1'b0, cy[0]);
         end
         FUNC_CPL:  return flag_word(a ^ 'hFF, 1'b1, zi, 1'b1, 1'b1, ci);
         FUNC_SCF:  return flag_word(a, 1'b0, zi, 1'b0, 1'b0, 1'b1);
         FUNC_CCF:  return flag_word(a, 1'b0, zi, 1'b0, 1'b0, !ci);
         FUNC_RLCA: return flag_word(((a << 1) | (a >> 7)) & 'hFF, 1'b1, 1'b0, 1'b0, 1'b0,
                                     a[7]);
         FUNC_RLA:  return flag_word(((a << 1) | ci) & 'hFF, 1'b1, 1'b0, 1'b0, 1'b0, a[7]);
         FUNC_RRCA: return flag_word((a >> 1) | (a[0] << 7), 1'b1, 1'b0, 1'b0, 1'b0, a[0]);
         FUNC_RRA:  return flag_word((a >> 1) | (ci << 7), 1'b1, 1'b0, 1'b0, 1'b0, a[0]);
         FUNC_ADD16: begin
            r  = wa + wb;
            hc = ((wa & 'hFFF) + (wb & 'hFFF)) >= 'h1000;
            return flag_word(r & 'hFFFF, 1'b1, zi, 1'b0, hc, r >= 'h10000);
         end
         FUNC_ADDSP: begin
            t  = b[7] ? (b | 'hFF00) : b;
            r  = (wa + t) & 'hFFFF;
            hc = ((wa & 'hF) + (b & 'hF)) >= 'h10;
            return flag_word(r, 1'b1, 1'b0, 1'b0, hc, ((wa & 'hFF) + b) >= 'h100);
         end
         default: return flag_word(wa, 1'b0, zi, ni, hi, ci);
      endcase
   endfunction

   always @(posedge clock) begin
      alu_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_q.push_back(alu_outcome(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               if (reports < REPORT_LIMIT) begin
                  reports++;
                  $display("unexpected result word %h", rsp_data);
               end
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.result       !== want.result       ||
                   rsp_data.write_result !== want.write_result ||
                   rsp_data.zero_out     !== want.zero_out     ||
                   rsp_data.subtract_out !== want.subtract_out ||
                   rsp_data.half_out     !== want.half_out     ||
                   rsp_data.carry_out    !== want.carry_out) begin
                  errors++;
                  if (reports < REPORT_LIMIT) begin
                     reports++;
                     $display("mismatch: expected result %h wr %b znhc %b%b%b%b",
                              want.result, want.write_result, want.zero_out,
                              want.subtract_out, want.half_out, want.carry_out);
                     $display("          actual   result %h wr %b znhc %b%b%b%b",
                              rsp_data.result, rsp_data.write_result,
                              rsp_data.zero_out, rsp_data.subtract_out,
                              rsp_data.half_out, rsp_data.carry_out);
                  end
               end
            end
         end
      end
      fail_count    <= errors;
      pending_count <= expected_q.size();
   end

endmodule

### test/sm83_alu_with_flags_unit_tb.sv
// ----------------------------------------------------------------------------
// sm83_alu_with_flags_unit_tb
// Drives the ALU with a directed sweep of every operation and its corner
// cases, then a long random stream sent in bursts, while the result side
// stalls in changing patterns. The checker beside the block predicts and
// compares every word; this top gives the verdict.
// ----------------------------------------------------------------------------
module sm83_alu_with_flags_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import smalu_pkg::*;

   localparam int RANDOM_WORDS = 400;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 4;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   alu_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   alu_rsp_type rsp_data;
   int          fail_count;
   int          pending_count;
   int          idle_cycles = 0;
   int          stall_left  = 0;
   int          rx_cycle    = 0;

   always #5 clock = ~clock;

   sm83_alu_with_flags_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   sm83_alu_with_flags_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      rx_cycle++;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         case ((rx_cycle / 128) % 3)
            1: if ($urandom_range(3, 0) == 0) stall_left = $urandom_range(3, 1);
            2: if ($urandom_range(1, 0) == 0) stall_left = $urandom_range(12, 1);
            default: ;
         endcase
         rsp_ready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(input alu_req_type w);
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_op(input logic [4:0] f, input logic [15:0] a, input logic [15:0] b,
                          input logic [3:0] znhc);
      alu_req_type w;
      w.func      = f;
      w.operand_a = a;
      w.operand_b = b;
      {w.zero_in, w.subtract_in, w.half_in, w.carry_in} = znhc;
      send_word(w);
   endtask

   function automatic logic [7:0] corner_byte();
      case ($urandom_range(7, 0))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h0F;
         3: return 8'hF0;
         4: return 8'h80;
         5: return 8'h7F;
         6: return 8'h99;
         default: return 8'h9A;
      endcase
   endfunction

   function automatic alu_req_type random_word();
      alu_req_type w;
      w.func      = ($urandom_range(15, 0) == 0) ? 5'($urandom_range(31, 20))
                                                 : 5'($urandom_range(19, 0));
      w.operand_a = 16'($urandom);
      w.operand_b = 16'($urandom);
      if ($urandom_range(3, 0) == 0) w.operand_a[7:0] = corner_byte();
      if ($urandom_range(3, 0) == 0) w.operand_b[7:0] = corner_byte();
      {w.zero_in, w.subtract_in, w.half_in, w.carry_in} = 4'($urandom_range(15, 0));
      return w;
   endfunction

   initial begin
      int sent;
      int burst;
      int gap;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_op(FUNC_ADD,   16'hAAFF, 16'h5501, 4'b0000);
      send_op(FUNC_ADC,   16'h000F, 16'h0000, 4'b0001);
      send_op(FUNC_SUB,   16'h0000, 16'h0001, 4'b0000);
      send_op(FUNC_SBC,   16'h0010, 16'h000F, 4'b0001);
      send_op(FUNC_AND,   16'h00F0, 16'h000F, 4'b0000);
      send_op(FUNC_XOR,   16'hFFFF, 16'hFFFF, 4'b1111);
      send_op(FUNC_OR,    16'h0000, 16'h0080, 4'b0000);
      send_op(FUNC_CP,    16'h0042, 16'h0042, 4'b0000);
      send_op(FUNC_INC,   16'h12FF, 16'h0000, 4'b0001);
      send_op(FUNC_DEC,   16'h0000, 16'h0000, 4'b0000);
      send_op(FUNC_DEC,   16'h0010, 16'h0000, 4'b0001);
      send_op(FUNC_DAA,   16'h009A, 16'h0000, 4'b0000);
      send_op(FUNC_DAA,   16'h0000, 16'h0000, 4'b0010);
      send_op(FUNC_DAA,   16'h0000, 16'h0000, 4'b0111);
      send_op(FUNC_CPL,   16'h005A, 16'h0000, 4'b1001);
      send_op(FUNC_SCF,   16'hFF3C, 16'h0000, 4'b1110);
      send_op(FUNC_CCF,   16'h003C, 16'h0000, 4'b0001);
      send_op(FUNC_RLCA,  16'h0080, 16'h0000, 4'b1000);
      send_op(FUNC_RLA,   16'h0080, 16'h0000, 4'b0000);
      send_op(FUNC_RRCA,  16'h0001, 16'h0000, 4'b1000);
      send_op(FUNC_RRA,   16'h0001, 16'h0000, 4'b0001);
      send_op(FUNC_ADD16, 16'hFFFF, 16'h0001, 4'b1000);
      send_op(FUNC_ADD16, 16'h0FFF, 16'h0001, 4'b0000);
      send_op(FUNC_ADDSP, 16'hFFFF, 16'h0001, 4'b1111);
      send_op(FUNC_ADDSP, 16'h0000, 16'h0080, 4'b0000);
      send_op(5'd20,      16'hFFFF, 16'hFFFF, 4'b1111);
      send_op(5'd31,      16'h1234, 16'h0000, 4'b0000);

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(24, 1);
         for (int i = 0; i < burst && sent < RANDOM_WORDS; i++) begin
            send_word(random_word());
            sent++;
         end
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### files.f
rtl/smalu_pkg.sv
rtl/sm83_alu_with_flags_unit.sv
test/sm83_alu_with_flags_checker.sv
test/sm83_alu_with_flags_unit_tb.sv
